// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Word format defaults, command codes and the control word that rides along
// the divide/square-root cell chain.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_WORD_WIDTH = 32;
    localparam int CAU_FRAC_BITS  = 16;
    localparam int CMD_W          = 3;

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIST = 3'd4;

    // Control that travels with one request through the cell chain
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic             dbz;
        logic             neg_re;
        logic             neg_im;
    } t_cau_ctrl;

endpackage

// ===== hdl/cau_if.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit channels
// Request channel (command and two complex operands) and response channel
// (complex result and flags), both valid/ready.
// ----------------------------------------------------------------------------
interface cau_req_if #(
    parameter int WORD_WIDTH = cau_pkg::CAU_WORD_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic [cau_pkg::CMD_W-1:0]    command;
    logic signed [WORD_WIDTH-1:0] a_real;
    logic signed [WORD_WIDTH-1:0] a_imag;
    logic signed [WORD_WIDTH-1:0] b_real;
    logic signed [WORD_WIDTH-1:0] b_imag;

    modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if #(
    parameter int WORD_WIDTH = cau_pkg::CAU_WORD_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] res_real;
    logic signed [WORD_WIDTH-1:0] res_imag;
    logic                         saturated;
    logic                         divide_by_zero;

    modport source (output valid, res_real, res_imag, saturated, divide_by_zero, input ready);
    modport sink   (input valid, res_real, res_imag, saturated, divide_by_zero, output ready);
endinterface

// ===== hdl/complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and distance on signed fixed-point complex
// operands, saturating results.
// ----------------------------------------------------------------------------
// Fully pipelined: one request is taken every cycle while no result waits on
// the response channel. Each request passes through
// 4 + (2*WORD_WIDTH+1+FRAC_BITS) + 1 register stages (86 at the default
// Q16.16). The stage count is set by the divide chain: one cell per quotient
// bit, each of the first WORD_WIDTH+1 cells also running one digit of the
// distance square root. Four operand stages (input, products, sums,
// sign/saturate) lead the chain and one packing register ends it. The whole
// pipeline holds while a result waits on the response channel.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top #(
    parameter int WORD_WIDTH = cau_pkg::CAU_WORD_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_req_if.sink    i_req,
    cau_rsp_if.source  o_rsp
);
    import cau_pkg::*;

    localparam int W     = WORD_WIDTH;
    localparam int PW    = 2*W+2;
    localparam int MW    = 2*W+1;
    localparam int DW    = 2*W+1;
    localparam int DD    = DW+FRAC_BITS;
    localparam int NSTEP = DD;
    localparam int RT    = W+1;
    localparam int RW    = 2*RT;
    localparam int SR    = RT+2;
    localparam int SW    = 2*W+1;

    // Saturate a sign/magnitude value into the word: {sat, value}
    function automatic logic [W:0] f_pack(input logic neg, input logic [PW-1:0] mag);
        logic [PW-1:0] lim;
        logic [PW-1:0] bound;
        logic          sat;
        logic [W-1:0]  m;
        lim   = PW'(1) << (W-1);
        bound = neg ? lim : lim - PW'(1);
        sat   = (mag > bound);
        m     = sat ? bound[W-1:0] : mag[W-1:0];
        return {sat, (neg ? (W'(0) - m) : m)};
    endfunction

    logic en;
    logic r_o_valid;

    assign en          = !r_o_valid || o_rsp.ready;
    assign i_req.ready = en;

    // Stage 1: capture the request, form the differences
    logic                 r1_valid;
    logic [CMD_W-1:0]     r1_cmd;
    logic signed [W-1:0]  r1_ar, r1_ai, r1_br, r1_bi;
    logic signed [W:0]    r1_dr, r1_di;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd <= i_req.command;
            r1_ar  <= i_req.a_real;
            r1_ai  <= i_req.a_imag;
            r1_br  <= i_req.b_real;
            r1_bi  <= i_req.b_imag;
            r1_dr  <= (W+1)'(i_req.a_real) - (W+1)'(i_req.b_real);
            r1_di  <= (W+1)'(i_req.a_imag) - (W+1)'(i_req.b_imag);
        end
    end

    // Stage 2: cross products, squares and the add/subtract sum
    logic                  r2_valid;
    logic [CMD_W-1:0]      r2_cmd;
    logic signed [2*W-1:0] r2_prr, r2_pii, r2_pri, r2_pir;
    logic signed [PW-1:0]  r2_sq1, r2_sq2;
    logic signed [W:0]     r2_as;
    logic signed [W:0]     n2_x1, n2_x2;
    logic signed [PW-1:0]  n2_sq1, n2_sq2;

    assign n2_x1  = (r1_cmd == CMD_DIST) ? r1_dr : (W+1)'(r1_br);
    assign n2_x2  = (r1_cmd == CMD_DIST) ? r1_di : (W+1)'(r1_bi);
    assign n2_sq1 = n2_x1 * n2_x1;
    assign n2_sq2 = n2_x2 * n2_x2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd <= r1_cmd;
            r2_prr <= r1_ar * r1_br;
            r2_pii <= r1_ai * r1_bi;
            r2_pri <= r1_ar * r1_bi;
            r2_pir <= r1_ai * r1_br;
            r2_sq1 <= n2_sq1;
            r2_sq2 <= n2_sq2;
            r2_as  <= (r1_cmd == CMD_SUB) ? ((W+1)'(r1_ar) - (W+1)'(r1_br))
                                          : ((W+1)'(r1_ar) + (W+1)'(r1_br));
        end
    end

    // Stage 3: combine products into numerators and the squared sum
    logic                 r3_valid;
    logic [CMD_W-1:0]     r3_cmd;
    logic signed [MW-1:0] r3_mre, r3_mim, r3_nre, r3_nim;
    logic [RW-1:0]        r3_sqsum;
    logic signed [W:0]    r3_as;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cmd   <= r2_cmd;
            r3_mre   <= MW'(r2_prr) - MW'(r2_pii);
            r3_mim   <= MW'(r2_pri) + MW'(r2_pir);
            r3_nre   <= MW'(r2_prr) + MW'(r2_pii);
            r3_nim   <= MW'(r2_pir) - MW'(r2_pri);
            r3_sqsum <= RW'(r2_sq1) + RW'(r2_sq2);
            r3_as    <= r2_as;
        end
    end

    // Stage 4: sign/magnitude split, finish add/subtract/multiply
    logic [MW-1:0] n4_mre_abs, n4_mim_abs, n4_nre_abs, n4_nim_abs;
    logic [MW-1:0] n4_mre_mag, n4_mim_mag;
    logic [W:0]    n4_as_abs;
    logic [W:0]    n4_pk_re, n4_pk_im;
    logic [SW-1:0] n4_side;
    t_cau_ctrl     n4_ctrl;

    assign n4_mre_abs = r3_mre[MW-1] ? (MW'(0) - r3_mre) : r3_mre;
    assign n4_mim_abs = r3_mim[MW-1] ? (MW'(0) - r3_mim) : r3_mim;
    assign n4_nre_abs = r3_nre[MW-1] ? (MW'(0) - r3_nre) : r3_nre;
    assign n4_nim_abs = r3_nim[MW-1] ? (MW'(0) - r3_nim) : r3_nim;
    assign n4_mre_mag = n4_mre_abs >> FRAC_BITS;
    assign n4_mim_mag = n4_mim_abs >> FRAC_BITS;
    assign n4_as_abs  = r3_as[W] ? ((W+1)'(0) - r3_as) : r3_as;

    always_comb begin
        n4_pk_re = '0;
        n4_pk_im = '0;
        case (r3_cmd)
            CMD_ADD, CMD_SUB: begin
                n4_pk_re = f_pack(r3_as[W], PW'(n4_as_abs));
                n4_pk_im = '0;
            end
            CMD_MUL: begin
                n4_pk_re = f_pack(r3_mre[MW-1] && (n4_mre_mag != '0), PW'(n4_mre_mag));
                n4_pk_im = f_pack(r3_mim[MW-1] && (n4_mim_mag != '0), PW'(n4_mim_mag));
            end
            default: begin
                n4_pk_re = '0;
                n4_pk_im = '0;
            end
        endcase
    end

    // Add/subtract needs a second sum for the imaginary part
    logic signed [W:0] r3_as_im;
    logic signed [W:0] r2_as_im;
    logic [W:0]        n4_asi_abs;
    logic [W:0]        n4_pk_asi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_as_im <= (r1_cmd == CMD_SUB) ? ((W+1)'(r1_ai) - (W+1)'(r1_bi))
                                            : ((W+1)'(r1_ai) + (W+1)'(r1_bi));
            r3_as_im <= r2_as_im;
        end
    end

    assign n4_asi_abs = r3_as_im[W] ? ((W+1)'(0) - r3_as_im) : r3_as_im;
    assign n4_pk_asi  = f_pack(r3_as_im[W], PW'(n4_asi_abs));

    always_comb begin
        n4_side = '0;
        if (r3_cmd == CMD_ADD || r3_cmd == CMD_SUB) begin
            n4_side = {n4_pk_re[W-1:0], n4_pk_asi[W-1:0], n4_pk_re[W] | n4_pk_asi[W]};
        end else begin
            n4_side = {n4_pk_re[W-1:0], n4_pk_im[W-1:0], n4_pk_re[W] | n4_pk_im[W]};
        end
    end

    assign n4_ctrl.valid  = r3_valid;
    assign n4_ctrl.cmd    = r3_cmd;
    assign n4_ctrl.dbz    = (r3_cmd == CMD_DIV) && (r3_sqsum == '0);
    assign n4_ctrl.neg_re = r3_nre[MW-1];
    assign n4_ctrl.neg_im = r3_nim[MW-1];

    // Chain wiring: index 0 is the stage-4 register
    t_cau_ctrl     c_ctrl   [0:NSTEP];
    logic [DW-1:0] c_den    [0:NSTEP];
    logic [DD-1:0] c_dvd_re [0:NSTEP];
    logic [DD-1:0] c_dvd_im [0:NSTEP];
    logic [DW-1:0] c_rem_re [0:NSTEP];
    logic [DW-1:0] c_rem_im [0:NSTEP];
    logic [W:0]    c_q_re   [0:NSTEP];
    logic [W:0]    c_q_im   [0:NSTEP];
    logic          c_big_re [0:NSTEP];
    logic          c_big_im [0:NSTEP];
    logic [RW-1:0] c_rad    [0:NSTEP];
    logic [SR-1:0] c_srem   [0:NSTEP];
    logic [RT-1:0] c_root   [0:NSTEP];
    logic [SW-1:0] c_side   [0:NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctrl[0] <= '0;
        end else if (en) begin
            c_ctrl[0] <= n4_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            c_den[0]    <= r3_sqsum[DW-1:0];
            c_dvd_re[0] <= {n4_nre_abs, {FRAC_BITS{1'b0}}};
            c_dvd_im[0] <= {n4_nim_abs, {FRAC_BITS{1'b0}}};
            c_rad[0]    <= r3_sqsum;
            c_side[0]   <= n4_side;
        end
    end

    assign c_rem_re[0] = '0;
    assign c_rem_im[0] = '0;
    assign c_q_re[0]   = '0;
    assign c_q_im[0]   = '0;
    assign c_big_re[0] = 1'b0;
    assign c_big_im[0] = 1'b0;
    assign c_srem[0]   = '0;
    assign c_root[0]   = '0;

    for (genvar g = 0; g < NSTEP; g++) begin : g_cell
        cau_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .SQRT_ON    (g < RT)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_ctrl   (c_ctrl[g]),
            .i_den    (c_den[g]),
            .i_dvd_re (c_dvd_re[g]),
            .i_dvd_im (c_dvd_im[g]),
            .i_rem_re (c_rem_re[g]),
            .i_rem_im (c_rem_im[g]),
            .i_q_re   (c_q_re[g]),
            .i_q_im   (c_q_im[g]),
            .i_big_re (c_big_re[g]),
            .i_big_im (c_big_im[g]),
            .i_rad    (c_rad[g]),
            .i_srem   (c_srem[g]),
            .i_root   (c_root[g]),
            .i_side   (c_side[g]),
            .o_ctrl   (c_ctrl[g+1]),
            .o_den    (c_den[g+1]),
            .o_dvd_re (c_dvd_re[g+1]),
            .o_dvd_im (c_dvd_im[g+1]),
            .o_rem_re (c_rem_re[g+1]),
            .o_rem_im (c_rem_im[g+1]),
            .o_q_re   (c_q_re[g+1]),
            .o_q_im   (c_q_im[g+1]),
            .o_big_re (c_big_re[g+1]),
            .o_big_im (c_big_im[g+1]),
            .o_rad    (c_rad[g+1]),
            .o_srem   (c_srem[g+1]),
            .o_root   (c_root[g+1]),
            .o_side   (c_side[g+1])
        );
    end

    // Output stage: finish divide and distance, select by command
    t_cau_ctrl     e_ctrl;
    logic [PW-1:0] e_qmag_re, e_qmag_im;
    logic [W:0]    e_pk_re, e_pk_im, e_pk_dist;
    logic [W-1:0]  n_re, n_im;
    logic          n_sat, n_dbz;
    logic [W-1:0]  r_re, r_im;
    logic          r_sat, r_dbz;

    assign e_ctrl    = c_ctrl[NSTEP];
    assign e_qmag_re = PW'({c_big_re[NSTEP], c_q_re[NSTEP]});
    assign e_qmag_im = PW'({c_big_im[NSTEP], c_q_im[NSTEP]});
    assign e_pk_re   = f_pack(e_ctrl.neg_re && (e_qmag_re != '0), e_qmag_re);
    assign e_pk_im   = f_pack(e_ctrl.neg_im && (e_qmag_im != '0), e_qmag_im);
    assign e_pk_dist = f_pack(1'b0, PW'(c_root[NSTEP]));

    always_comb begin
        n_re  = '0;
        n_im  = '0;
        n_sat = 1'b0;
        n_dbz = 1'b0;
        case (e_ctrl.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                n_re  = c_side[NSTEP][SW-1 -: W];
                n_im  = c_side[NSTEP][W:1];
                n_sat = c_side[NSTEP][0];
            end
            CMD_DIV: begin
                if (e_ctrl.dbz) begin
                    n_dbz = 1'b1;
                end else begin
                    n_re  = e_pk_re[W-1:0];
                    n_im  = e_pk_im[W-1:0];
                    n_sat = e_pk_re[W] | e_pk_im[W];
                end
            end
            CMD_DIST: begin
                n_re  = e_pk_dist[W-1:0];
                n_sat = e_pk_dist[W];
            end
            default: begin
                n_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= e_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_sat <= n_sat;
            r_dbz <= n_dbz;
        end
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.res_real       = r_re;
    assign o_rsp.res_imag       = r_im;
    assign o_rsp.saturated      = r_sat;
    assign o_rsp.divide_by_zero = r_dbz;

endmodule

// ===== hdl/cau_cell.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit chain cell
// One restoring-division step for both quotient parts and, where enabled,
// one digit step of the integer square root; hands all state to the next cell.
// ----------------------------------------------------------------------------
module cau_cell #(
    parameter int WORD_WIDTH = cau_pkg::CAU_WORD_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS,
    parameter bit SQRT_ON    = 1'b1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  cau_pkg::t_cau_ctrl         i_ctrl,
    input  logic [2*WORD_WIDTH:0]      i_den,
    input  logic [2*WORD_WIDTH+FRAC_BITS:0] i_dvd_re,
    input  logic [2*WORD_WIDTH+FRAC_BITS:0] i_dvd_im,
    input  logic [2*WORD_WIDTH:0]      i_rem_re,
    input  logic [2*WORD_WIDTH:0]      i_rem_im,
    input  logic [WORD_WIDTH:0]        i_q_re,
    input  logic [WORD_WIDTH:0]        i_q_im,
    input  logic                       i_big_re,
    input  logic                       i_big_im,
    input  logic [2*WORD_WIDTH+1:0]    i_rad,
    input  logic [WORD_WIDTH+2:0]      i_srem,
    input  logic [WORD_WIDTH:0]        i_root,
    input  logic [2*WORD_WIDTH:0]      i_side,
    output cau_pkg::t_cau_ctrl         o_ctrl,
    output logic [2*WORD_WIDTH:0]      o_den,
    output logic [2*WORD_WIDTH+FRAC_BITS:0] o_dvd_re,
    output logic [2*WORD_WIDTH+FRAC_BITS:0] o_dvd_im,
    output logic [2*WORD_WIDTH:0]      o_rem_re,
    output logic [2*WORD_WIDTH:0]      o_rem_im,
    output logic [WORD_WIDTH:0]        o_q_re,
    output logic [WORD_WIDTH:0]        o_q_im,
    output logic                       o_big_re,
    output logic                       o_big_im,
    output logic [2*WORD_WIDTH+1:0]    o_rad,
    output logic [WORD_WIDTH+2:0]      o_srem,
    output logic [WORD_WIDTH:0]        o_root,
    output logic [2*WORD_WIDTH:0]      o_side
);
    import cau_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int DW = 2*W+1;
    localparam int DD = DW+FRAC_BITS;
    localparam int RT = W+1;
    localparam int SR = RT+2;

    // One restoring division step: returns {quotient bit, new remainder}
    function automatic logic [DW:0] f_div_step(input logic [DW-1:0] rem,
                                               input logic bitin,
                                               input logic [DW-1:0] den);
        logic [DW:0] t;
        logic        ge;
        logic [DW:0] d;
        t  = {rem, bitin};
        ge = (t >= {1'b0, den});
        d  = ge ? (t - {1'b0, den}) : t;
        return {ge, d[DW-1:0]};
    endfunction

    logic [DW:0]   w_re;
    logic [DW:0]   w_im;
    logic [SR+1:0] w_st;
    logic [SR+1:0] w_trial;
    logic          w_sge;
    logic [SR+1:0] w_sd;

    assign w_re    = f_div_step(i_rem_re, i_dvd_re[DD-1], i_den);
    assign w_im    = f_div_step(i_rem_im, i_dvd_im[DD-1], i_den);
    assign w_st    = {i_srem, i_rad[2*RT-1 -: 2]};
    assign w_trial = (SR+2)'({i_root, 2'b01});
    assign w_sge   = (w_st >= w_trial);
    assign w_sd    = w_sge ? (w_st - w_trial) : w_st;

    // Advance one step with the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else if (i_en) begin
            o_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den    <= i_den;
            o_side   <= i_side;
            o_dvd_re <= {i_dvd_re[DD-2:0], 1'b0};
            o_dvd_im <= {i_dvd_im[DD-2:0], 1'b0};
            o_rem_re <= w_re[DW-1:0];
            o_rem_im <= w_im[DW-1:0];
            o_q_re   <= {i_q_re[W-1:0], w_re[DW]};
            o_q_im   <= {i_q_im[W-1:0], w_im[DW]};
            o_big_re <= i_big_re | i_q_re[W];
            o_big_im <= i_big_im | i_q_im[W];
            if (SQRT_ON) begin
                o_rad  <= {i_rad[2*RT-3:0], 2'b00};
                o_srem <= w_sd[SR-1:0];
                o_root <= {i_root[RT-2:0], w_sge};
            end else begin
                o_rad  <= i_rad;
                o_srem <= i_srem;
                o_root <= i_root;
            end
        end
    end

endmodule

// ===== hdl/cau_checker.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit port checker
// Watches the top-level channels for flag consistency, reset and flow rules.
// ----------------------------------------------------------------------------
module cau_checker #(
    parameter int WORD_WIDTH = cau_pkg::CAU_WORD_WIDTH
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [WORD_WIDTH-1:0] i_res_real,
    input logic [WORD_WIDTH-1:0] i_res_imag,
    input logic                  i_saturated,
    input logic                  i_divide_by_zero
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_res_real)
                                        && $stable(i_res_imag))
        else $error("stalled response changed");

    // Zero divisor gives a clean zero result
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_divide_by_zero |->
            i_res_real == '0 && i_res_imag == '0 && !i_saturated)
        else $error("divide by zero with nonzero result");

    // Drop the response after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // Take a request whenever no response is pending
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request blocked with empty output");

endmodule

bind complex_arithmetic_unit_top cau_checker #(.WORD_WIDTH(WORD_WIDTH)) u_cau_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_res_real       (o_rsp.res_real),
    .i_res_imag       (o_rsp.res_imag),
    .i_saturated      (o_rsp.saturated),
    .i_divide_by_zero (o_rsp.divide_by_zero)
);
